### rtl/ptt_pkg.sv
// ptt_pkg: shared types, operation codes and constants of the periodic timer table
// no dependencies
package ptt_pkg;

    localparam int TIME_W         = 48;
    localparam int IVL_W          = 32;
    localparam int DEF_MAX_TIMERS = 16;
    localparam int RESULT_LIMIT   = 16;
    localparam int RES_W          = $clog2(RESULT_LIMIT + 1);
    localparam int SNAP_FACTOR    = 100;

    typedef logic [2:0]        func_t;
    typedef logic [1:0]        status_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [IVL_W-1:0]  ivl_t;

    localparam func_t FUNC_TICK    = 3'd0;
    localparam func_t FUNC_ADD     = 3'd1;
    localparam func_t FUNC_SET_IVL = 3'd2;
    localparam func_t FUNC_ENABLE  = 3'd3;
    localparam func_t FUNC_DISABLE = 3'd4;

    localparam logic KIND_FIRE  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_FULL     = 2'd1;
    localparam status_t STATUS_NO_TIMER = 2'd2;

    // state of the tick evaluation pipeline seen by the sequencer
    typedef struct packed {
        logic active;
        logic valid;
        logic fire;
        logic report;
    } tick_eval_t;

endpackage

### rtl/ptt_ram.sv
// ptt_ram: generic single write port, single read port ram with registered read
// no dependencies
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ptt_tick_unit.sv
// ptt_tick_unit: three-stage deadline and snap evaluation, one timer entry per cycle
// depends on ptt_pkg; fed by the table rams of periodic_timer_table
module ptt_tick_unit #(
    parameter int MAX_TIMERS = ptt_pkg::DEF_MAX_TIMERS,
    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue,
    input  logic [AW-1:0]       issue_idx,
    input  ptt_pkg::time_t      now,
    input  ptt_pkg::time_t      rd_lft,
    input  ptt_pkg::ivl_t       rd_period,
    input  logic                rd_run,
    input  logic                rd_rep,
    output ptt_pkg::tick_eval_t eval,
    output logic [AW-1:0]       eval_idx,
    output ptt_pkg::time_t      new_lft
);
    import ptt_pkg::*;

    localparam logic [6:0] SNAP_MUL = 7'(SNAP_FACTOR + 1);

    logic                s0_v_reg;
    logic [AW-1:0]       s0_idx_reg;

    logic                s1_v_reg;
    logic [AW-1:0]       s1_idx_reg;
    logic [TIME_W-1:0]   s1_lft_reg;
    logic [TIME_W:0]     s1_deadline_reg;
    logic [IVL_W+6:0]    s1_p101_reg;
    logic                s1_run_reg;
    logic                s1_rep_reg;

    logic                s2_v_reg;
    logic [AW-1:0]       s2_idx_reg;
    logic [TIME_W:0]     s2_deadline_reg;
    logic [TIME_W+1:0]   s2_thr_reg;
    logic                s2_fire_reg;
    logic                s2_rep_reg;

    logic [TIME_W:0]     deadline_next;
    logic [IVL_W+6:0]    p101_next;
    logic [TIME_W+1:0]   thr_next;
    logic                fire_next;
    logic                snap;

    assign deadline_next = {1'b0, rd_lft} + {17'b0, rd_period};
    assign p101_next     = {7'b0, rd_period} * {32'b0, SNAP_MUL};
    assign thr_next      = {2'b0, s1_lft_reg} + {11'b0, s1_p101_reg};
    assign fire_next     = s1_run_reg && ({1'b0, now} >= s1_deadline_reg);
    // still lagging by 100 intervals after the advance
    assign snap          = {2'b0, now} >= s2_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= issue;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_idx_reg      <= issue_idx;
        s1_idx_reg      <= s0_idx_reg;
        s1_lft_reg      <= rd_lft;
        s1_deadline_reg <= deadline_next;
        s1_p101_reg     <= p101_next;
        s1_run_reg      <= rd_run;
        s1_rep_reg      <= rd_rep;
        s2_idx_reg      <= s1_idx_reg;
        s2_deadline_reg <= s1_deadline_reg;
        s2_thr_reg      <= thr_next;
        s2_fire_reg     <= fire_next;
        s2_rep_reg      <= s1_rep_reg;
    end

    assign eval.active = s0_v_reg || s1_v_reg || s2_v_reg;
    assign eval.valid  = s2_v_reg;
    assign eval.fire   = s2_fire_reg;
    assign eval.report = s2_rep_reg;
    assign eval_idx    = s2_idx_reg;
    assign new_lft     = snap ? now : s2_deadline_reg[TIME_W-1:0];

endmodule

### rtl/periodic_timer_table.sv
// periodic_timer_table: a table operation returns one reply item in the cycle after start
// with busy low, so items can follow back to back. A tick keeps busy high while it walks the table
// (one entry per cycle into a three-stage pipeline, then a closing step); on an empty
// table it gives no item and busy stays low. Fire items leave at most one per cycle, the
// last in the first cycle with busy low; the receiver cannot stall them.
// Reset clears the timer count and all control; table contents are undefined until added.
module periodic_timer_table #(
    parameter int MAX_TIMERS = ptt_pkg::DEF_MAX_TIMERS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ptt_pkg::func_t   func,
    input  ptt_pkg::time_t   now_time,
    input  logic [3:0]       timer_index,
    input  ptt_pkg::ivl_t    interval,
    input  logic             enable_flag,
    input  logic             report,
    output logic             done,
    output logic             kind,
    output logic [3:0]       which_timer,
    output ptt_pkg::status_t status,
    output logic             last
);
    import ptt_pkg::*;

    localparam int AW   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW   = $clog2(MAX_TIMERS + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;
    localparam int IW   = (AW > 4) ? AW : 4;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg,   state_next;
    logic [CW-1:0]    count_reg,   count_next;
    logic [CW-1:0]    ptr_reg,     ptr_next;
    time_t            now_reg,     now_next;
    logic             pend_v_reg,  pend_v_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    logic [RES_W-1:0] nres_reg,    nres_next;
    logic             done_reg,    done_next;
    logic             kind_reg,    kind_next;
    logic [3:0]       which_reg,   which_next;
    status_t          status_reg,  status_next;
    logic             last_reg,    last_next;

    logic             accept;
    logic [CMPW-1:0]  idx_ext;
    logic [CMPW-1:0]  cnt_ext;
    logic             idx_ok;
    logic             full;
    logic [IW-1:0]    pend_wide;
    logic             issue;

    logic             lft_we;
    logic [AW-1:0]    lft_waddr;
    time_t            lft_wdata;
    logic             per_we;
    logic [AW-1:0]    per_waddr;
    logic             run_we;
    logic [AW-1:0]    run_waddr;
    logic             run_wdata;
    logic             rep_we;

    time_t            rd_lft;
    ivl_t             rd_period;
    logic             rd_run;
    logic             rd_rep;

    tick_eval_t       eval;
    logic [AW-1:0]    eval_idx;
    time_t            new_lft;

    assign accept    = start && !busy;
    assign busy      = (state_reg == ST_RUN);
    assign idx_ext   = CMPW'(timer_index);
    assign cnt_ext   = CMPW'(count_reg);
    assign idx_ok    = idx_ext < cnt_ext;
    assign full      = count_reg == CW'(MAX_TIMERS);
    assign pend_wide = IW'(pend_idx_reg);

    ptt_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TIMERS)) u_lft_ram (
        .clk   (clk),
        .we    (lft_we),
        .waddr (lft_waddr),
        .wdata (lft_wdata),
        .re    (issue),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_lft)
    );

    ptt_ram #(.WIDTH(IVL_W), .DEPTH(MAX_TIMERS)) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (per_waddr),
        .wdata (interval),
        .re    (issue),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_period)
    );

    ptt_ram #(.WIDTH(1), .DEPTH(MAX_TIMERS)) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (run_waddr),
        .wdata (run_wdata),
        .re    (issue),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_run)
    );

    ptt_ram #(.WIDTH(1), .DEPTH(MAX_TIMERS)) u_rep_ram (
        .clk   (clk),
        .we    (rep_we),
        .waddr (cnt_ext[AW-1:0]),
        .wdata (report),
        .re    (issue),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_rep)
    );

    ptt_tick_unit #(.MAX_TIMERS(MAX_TIMERS)) u_tick_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_idx (ptr_reg[AW-1:0]),
        .now       (now_reg),
        .rd_lft    (rd_lft),
        .rd_period (rd_period),
        .rd_run    (rd_run),
        .rd_rep    (rd_rep),
        .eval      (eval),
        .eval_idx  (eval_idx),
        .new_lft   (new_lft)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        now_next      = now_reg;
        pend_v_next   = pend_v_reg;
        pend_idx_next = pend_idx_reg;
        nres_next     = nres_reg;
        done_next     = 1'b0;
        kind_next     = kind_reg;
        which_next    = which_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        issue         = 1'b0;
        lft_we        = 1'b0;
        lft_waddr     = idx_ext[AW-1:0];
        lft_wdata     = now_time;
        per_we        = 1'b0;
        per_waddr     = idx_ext[AW-1:0];
        run_we        = 1'b0;
        run_waddr     = idx_ext[AW-1:0];
        run_wdata     = 1'b0;
        rep_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func) inside
                        FUNC_TICK:
                        begin
                            now_next    = now_time;
                            ptr_next    = '0;
                            pend_v_next = 1'b0;
                            nres_next   = '0;
                            if (count_reg != '0)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        FUNC_ADD:
                        begin
                            done_next = 1'b1;
                            kind_next = KIND_REPLY;
                            last_next = 1'b1;
                            if (full)
                            begin
                                which_next  = 4'd0;
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                which_next  = cnt_ext[3:0];
                                status_next = STATUS_OK;
                                count_next  = count_reg + CW'(1);
                                lft_we      = 1'b1;
                                lft_waddr   = cnt_ext[AW-1:0];
                                per_we      = 1'b1;
                                per_waddr   = cnt_ext[AW-1:0];
                                run_we      = 1'b1;
                                run_waddr   = cnt_ext[AW-1:0];
                                run_wdata   = enable_flag;
                                rep_we      = 1'b1;
                            end
                        end
                        FUNC_SET_IVL, FUNC_ENABLE, FUNC_DISABLE:
                        begin
                            done_next  = 1'b1;
                            kind_next  = KIND_REPLY;
                            last_next  = 1'b1;
                            which_next = timer_index;
                            if (!idx_ok)
                            begin
                                status_next = STATUS_NO_TIMER;
                            end
                            else
                            begin
                                status_next = STATUS_OK;
                                unique case (func)
                                    FUNC_SET_IVL:
                                    begin
                                        per_we = 1'b1;
                                    end
                                    FUNC_ENABLE:
                                    begin
                                        lft_we    = 1'b1;
                                        run_we    = 1'b1;
                                        run_wdata = 1'b1;
                                    end
                                    default:
                                    begin
                                        run_we    = 1'b1;
                                        run_wdata = 1'b0;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (ptr_reg < count_reg)
                begin
                    issue    = 1'b1;
                    ptr_next = ptr_reg + CW'(1);
                end
                if (eval.valid && eval.fire)
                begin
                    lft_we    = 1'b1;
                    lft_waddr = eval_idx;
                    lft_wdata = new_lft;
                    if (eval.report && (nres_reg < RES_W'(RESULT_LIMIT)))
                    begin
                        nres_next     = nres_reg + RES_W'(1);
                        pend_v_next   = 1'b1;
                        pend_idx_next = eval_idx;
                        // the held item is not the final one
                        if (pend_v_reg)
                        begin
                            done_next   = 1'b1;
                            kind_next   = KIND_FIRE;
                            which_next  = pend_wide[3:0];
                            status_next = STATUS_OK;
                            last_next   = 1'b0;
                        end
                    end
                end
                if ((ptr_reg >= count_reg) && !eval.active)
                begin
                    state_next  = ST_IDLE;
                    pend_v_next = 1'b0;
                    if (pend_v_reg)
                    begin
                        done_next   = 1'b1;
                        kind_next   = KIND_FIRE;
                        which_next  = pend_wide[3:0];
                        status_next = STATUS_OK;
                        last_next   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            pend_v_reg <= 1'b0;
            nres_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            pend_v_reg <= pend_v_next;
            nres_reg   <= nres_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        pend_idx_reg <= pend_idx_next;
        kind_reg     <= kind_next;
        which_reg    <= which_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    assign done        = done_reg;
    assign kind        = kind_reg;
    assign which_timer = which_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

### rtl/ptt_checker.sv
// ptt_checker: port-level assertions for periodic_timer_table, attached by bind
// depends on ptt_pkg and periodic_timer_table
module ptt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input ptt_pkg::func_t   func,
    input logic             done,
    input logic             kind,
    input ptt_pkg::status_t status,
    input logic             last
);
    import ptt_pkg::*;

    // table operations answer in the next cycle
    a_reply_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_ADD || func == FUNC_SET_IVL ||
                            func == FUNC_ENABLE || func == FUNC_DISABLE))
        |=> (done && kind == KIND_REPLY))
        else $error("table operation without reply item");

    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind == KIND_REPLY) |-> last)
        else $error("reply item not flagged last");

    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind == KIND_FIRE) |-> (status == STATUS_OK))
        else $error("fire item with error status");

    // the final item of an input shows up once the block is free again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |-> !busy)
        else $error("final item while still busy");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .func   (func),
    .done   (done),
    .kind   (kind),
    .status (status),
    .last   (last)
);

### tb/tb_periodic_timer_table.sv
// tb_periodic_timer_table: self-checking testbench for the periodic timer table
// depends on ptt_pkg and periodic_timer_table; predicts fire and reply items in a scoreboard class
module tb_periodic_timer_table;
    timeunit 1ns;
    timeprecision 1ps;
    import ptt_pkg::*;

    localparam int TIMERS       = DEF_MAX_TIMERS;
    localparam int RANDOM_ITEMS = 410;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * (TIMERS + 4) + 8;

    typedef struct {
        func_t      op;
        time_t      at;
        logic [3:0] idx;
        ivl_t       ivl;
        logic       en;
        logic       rep;
    } command_t;

    typedef struct {
        logic       kind;
        logic [3:0] which;
        status_t    status;
        logic       last;
    } response_t;

    class fire_reply_tracker;
        logic [63:0] fire_time[TIMERS];
        ivl_t        period_ticks[TIMERS];
        logic        running[TIMERS];
        logic        reporting[TIMERS];
        int          timers_added;
        response_t   pending_responses[$];
        int          errors;

        function new();
            timers_added = 0;
            errors = 0;
        endfunction

        function void push_response(logic k, logic [3:0] w, status_t s, logic l);
            response_t r;
            r.kind = k;
            r.which = w;
            r.status = s;
            r.last = l;
            pending_responses.push_back(r);
        endfunction

        function void advance_timers(time_t at);
            logic [63:0] now64;
            logic [63:0] due;
            int fired;
            now64 = 64'(at);
            fired = 0;
            for (int i = 0; i < timers_added; i++)
            begin
                due = fire_time[i] + 64'(period_ticks[i]);
                if (running[i] && now64 >= due)
                begin
                    if (reporting[i] && fired < RESULT_LIMIT)
                    begin
                        push_response(KIND_FIRE, 4'(i), STATUS_OK, 1'b0);
                        fired++;
                    end
                    fire_time[i] = due;
                    if (now64 - due >= 64'(period_ticks[i]) * 64'(SNAP_FACTOR))
                        fire_time[i] = now64;
                end
            end
            if (fired > 0)
                pending_responses[pending_responses.size() - 1].last = 1'b1;
        endfunction

        function void accept_command(command_t c);
            case (c.op)
                FUNC_TICK: advance_timers(c.at);
                FUNC_ADD:
                begin
                    if (timers_added >= TIMERS)
                        push_response(KIND_REPLY, 4'd0, STATUS_FULL, 1'b1);
                    else
                    begin
                        fire_time[timers_added] = 64'(c.at);
                        period_ticks[timers_added] = c.ivl;
                        running[timers_added] = c.en;
                        reporting[timers_added] = c.rep;
                        push_response(KIND_REPLY, 4'(timers_added), STATUS_OK, 1'b1);
                        timers_added++;
                    end
                end
                FUNC_SET_IVL, FUNC_ENABLE, FUNC_DISABLE:
                begin
                    if (int'(c.idx) >= timers_added)
                        push_response(KIND_REPLY, c.idx, STATUS_NO_TIMER, 1'b1);
                    else
                    begin
                        if (c.op == FUNC_SET_IVL)
                            period_ticks[c.idx] = c.ivl;
                        else if (c.op == FUNC_ENABLE)
                        begin
                            running[c.idx] = 1'b1;
                            fire_time[c.idx] = 64'(c.at);
                        end
                        else
                            running[c.idx] = 1'b0;
                        push_response(KIND_REPLY, c.idx, STATUS_OK, 1'b1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_response(logic k, logic [3:0] w, status_t s, logic l);
            response_t e;
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected item kind %0d which %0d status %0d last %0d",
                         $realtime, k, w, s, l);
                errors++;
                return;
            end
            e = pending_responses.pop_front();
            if (k !== e.kind)
            begin
                $display("%0t: kind expected %0d actual %0d", $realtime, e.kind, k);
                errors++;
            end
            if (w !== e.which)
            begin
                $display("%0t: which_timer expected %0d actual %0d", $realtime, e.which, w);
                errors++;
            end
            if (s !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $realtime, e.status, s);
                errors++;
            end
            if (l !== e.last)
            begin
                $display("%0t: last expected %0d actual %0d", $realtime, e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    func_t      func = FUNC_TICK;
    time_t      now_time = '0;
    logic [3:0] timer_index = '0;
    ivl_t       interval = '0;
    logic       enable_flag = 1'b0;
    logic       report = 1'b0;
    logic       busy;
    logic       done;
    logic       kind;
    logic [3:0] which_timer;
    status_t    status;
    logic       last;

    fire_reply_tracker tracker = new();
    bit    calm = 1'b0;
    int    quiet_cycles = 0;
    time_t cur_time;

    periodic_timer_table #(.MAX_TIMERS(TIMERS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .now_time(now_time),
        .timer_index(timer_index),
        .interval(interval),
        .enable_flag(enable_flag),
        .report(report),
        .done(done),
        .kind(kind),
        .which_timer(which_timer),
        .status(status),
        .last(last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.compare_response(kind, which_timer, status, last);
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_command(command_t c);
        if (!calm && $urandom_range(0, 99) < 27)
            hold_off($urandom_range(0, 3) == 0 ? $urandom_range(4, 24) : $urandom_range(1, 3));
        start <= 1'b1;
        func <= c.op;
        now_time <= c.at;
        timer_index <= c.idx;
        interval <= c.ivl;
        enable_flag <= c.en;
        report <= c.rep;
        do
            @(posedge clk);
        while (busy);
        tracker.accept_command(c);
    endtask

    task automatic issue(func_t op, time_t at, logic [3:0] idx, ivl_t ivl,
                         logic en, logic rep);
        command_t c;
        c.op = op;
        c.at = at;
        c.idx = idx;
        c.ivl = ivl;
        c.en = en;
        c.rep = rep;
        send_command(c);
    endtask

    function automatic time_t any_time();
        return time_t'({16'($urandom()), 32'($urandom())});
    endfunction

    initial
    begin
        command_t c;
        int pick;
        int waited;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, errors and ignored codes
        issue(FUNC_TICK, 48'd5, 4'd0, 32'd0, 1'b0, 1'b0);
        issue(FUNC_SET_IVL, 48'd0, 4'd0, 32'd7, 1'b0, 1'b0);
        issue(FUNC_ENABLE, 48'd0, 4'd15, 32'd0, 1'b1, 1'b1);
        issue(func_t'(3'd5), 48'd1, 4'd3, 32'd1, 1'b1, 1'b1);
        issue(func_t'(3'd7), 48'd1, 4'd3, 32'd1, 1'b1, 1'b1);

        // fill the table, then overflow it
        issue(FUNC_ADD, 48'd0, 4'd9, 32'd0, 1'b1, 1'b1);
        issue(FUNC_ADD, 48'hFFFF_FFFF_FFFF, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        for (int i = 2; i < TIMERS; i++)
            issue(FUNC_ADD, 48'd0, 4'd0, ivl_t'(60 * (i - 1)), i != 5, i != 7);
        issue(FUNC_ADD, 48'd0, 4'd15, 32'd3, 1'b1, 1'b1);

        issue(FUNC_TICK, 48'd1000, 4'd0, 32'd0, 1'b0, 1'b0);
        issue(FUNC_SET_IVL, 48'd0, 4'd15, 32'd0, 1'b0, 1'b0);
        issue(FUNC_ENABLE, 48'd1000, 4'd1, 32'd0, 1'b0, 1'b0);
        issue(FUNC_DISABLE, 48'd0, 4'd0, 32'd0, 1'b0, 1'b0);

        cur_time = 48'd1000;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 150 && n < 250);
            pick = $urandom_range(0, 99);
            c.idx = 4'($urandom_range(0, 15));
            c.ivl = $urandom();
            c.en = 1'($urandom());
            c.rep = 1'($urandom());
            c.at = cur_time;
            if (pick < 55)
            begin
                c.op = FUNC_TICK;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    cur_time = cur_time + time_t'($urandom_range(100000, 10000000));
                else if (pick >= 5)
                    cur_time = cur_time + time_t'($urandom_range(0, 300));
                c.at = (pick >= 3 && pick < 5) ? any_time() : cur_time;
            end
            else if (pick < 67)
            begin
                c.op = FUNC_SET_IVL;
                if ($urandom_range(0, 4) != 0)
                    c.ivl = ivl_t'($urandom_range(0, 200));
            end
            else if (pick < 79)
            begin
                c.op = FUNC_ENABLE;
                if ($urandom_range(0, 9) == 0)
                    c.at = any_time();
            end
            else if (pick < 91)
                c.op = FUNC_DISABLE;
            else if (pick < 96)
            begin
                c.op = FUNC_ADD;
                c.at = any_time();
            end
            else
                c.op = func_t'($urandom_range(5, 7));
            send_command(c);
        end
        calm = 1'b0;
        hold_off(0);

        waited = 0;
        while (tracker.pending_responses.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending_responses.size() != 0)
            $display("%0t: %0d expected items never arrived", $realtime,
                     tracker.pending_responses.size());
        if (tracker.errors == 0 && tracker.pending_responses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
